>>> hdl/srbt_pkg.sv
// Shared types, codes and sizes for the search retry backoff table.
// No dependencies; imported by every module of the block.
package srbt_pkg;

  localparam int TABLE_SLOTS = 32;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int HELD_W      = $clog2(TABLE_SLOTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] PASS_GAP_RESET = 16'd100;
  localparam logic [15:0] CEILING_RESET  = 16'd256;
  localparam logic [15:0] FALLBACK_RESET = 16'd129;

  localparam logic [1:0] CFG_PASS_GAP = 2'd0;
  localparam logic [1:0] CFG_CEILING  = 2'd1;
  localparam logic [1:0] CFG_FALLBACK = 2'd2;

  localparam logic [2:0] MODE_REGISTER   = 3'd0;
  localparam logic [2:0] MODE_UNREGISTER = 3'd1;
  localparam logic [2:0] MODE_RESPONSE   = 3'd2;
  localparam logic [2:0] MODE_NEW_SERVER = 3'd3;
  localparam logic [2:0] MODE_TICK       = 3'd4;

  typedef enum logic [2:0] {
    S_DONE       = 3'd0,
    S_NOT_FOUND  = 3'd1,
    S_TABLE_FULL = 3'd2,
    S_SUPPRESSED = 3'd3,
    S_PASS_EMPTY = 3'd4,
    S_SEARCH     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_REGISTER,
    OP_REMOVE,
    OP_BOOST,
    OP_TICK,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_EDIT,
    ST_GAP,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] channel_id;
    logic        penalize;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] search_id;
    logic        last;
    logic [6:0]  entries_held;
  } rsp_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] channel_id;
    logic        penalize;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pass_gap_ms;
    logic [15:0] count_ceiling;
    logic [15:0] fallback_count;
  } cfg_t;

endpackage

>>> hdl/srbt_front.sv
// Request intake: decodes the mode into a command and holds it in a short queue.
// Depends on srbt_pkg.
module srbt_front import srbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_pop
);

  cmd_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] cnt;
  cmd_t              decoded;
  logic              push;

  always_comb begin
    decoded.channel_id = req.channel_id;
    decoded.penalize   = req.penalize;
    decoded.now_ms     = req.now_ms;
    unique case (req.mode)
      MODE_REGISTER:                 decoded.op = OP_REGISTER;
      MODE_UNREGISTER, MODE_RESPONSE: decoded.op = OP_REMOVE;
      MODE_NEW_SERVER:               decoded.op = OP_BOOST;
      MODE_TICK:                     decoded.op = OP_TICK;
      default:                       decoded.op = OP_NOP;
    endcase
  end

  assign req_ready = cnt != QCNT_W'(QUEUE_DEPTH);
  assign push      = req_valid && req_ready;
  assign cmd_valid = cnt != '0;
  assign cmd       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= decoded;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (cmd_pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      cnt <= cnt + QCNT_W'(push) - QCNT_W'(cmd_pop);
    end
  end

endmodule

>>> hdl/srbt_back.sv
// Table engine: sorted id table, one-slot-a-cycle scans, passes and response staging.
// The pass walk holds while the response stage is full. Depends on srbt_pkg.
module srbt_back import srbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic [31:0]       ids  [TABLE_SLOTS];
  logic [15:0]       cnts [TABLE_SLOTS];
  logic [HELD_W-1:0] held;
  logic [HELD_W-1:0] idx;
  logic [31:0]       last_pass;
  logic              found;
  cmd_t              cur;
  state_t            state;
  state_t            state_next;
  rsp_t              pend;
  logic              pend_valid;

  logic [SLOT_W-1:0] sidx;
  logic              in_range;
  logic [31:0]       id_at;
  logic [15:0]       cnt_at;
  logic              scan_more;
  logic              hit;
  logic              full;
  logic              reject;
  logic [HELD_W-1:0] held_after;
  logic              too_soon;
  logic              at_end;
  logic              pow2;
  logic [15:0]       cnt_step;
  logic [15:0]       start;
  logic              slot_free;
  logic              can_emit;
  logic              emit_en;
  logic              flush_en;
  status_t           emit_status;
  logic [31:0]       emit_id;
  logic [HELD_W-1:0] emit_held;

  assign sidx       = idx[SLOT_W-1:0];
  assign in_range   = idx < held;
  assign id_at      = ids[sidx];
  assign cnt_at     = cnts[sidx];
  assign scan_more  = in_range && (id_at < cur.channel_id);
  assign hit        = in_range && (id_at == cur.channel_id);
  assign full       = held == HELD_W'(TABLE_SLOTS);
  assign reject     = !hit && full;
  assign held_after = hit ? held : held + 1'b1;
  assign too_soon   = (cur.now_ms - last_pass) < {16'd0, cfg.pass_gap_ms};
  assign at_end     = idx == held;
  assign pow2       = (cnt_at != '0) && ((cnt_at & (cnt_at - 16'd1)) == '0);
  assign cnt_step   = (cnt_at >= cfg.count_ceiling) ? cfg.fallback_count : cnt_at + 16'd1;
  assign start      = cur.penalize ? cfg.fallback_count : 16'd1;
  assign slot_free  = !rsp_valid || rsp_ready;
  assign can_emit   = !pend_valid || slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_REGISTER, OP_REMOVE: state_next = ST_FIND;
            OP_BOOST, OP_TICK:      state_next = ST_GAP;
            default:                state_next = ST_EDIT;
          endcase
        end
      end
      ST_FIND: begin
        if (!scan_more) state_next = ST_EDIT;
      end
      ST_EDIT: begin
        if (can_emit) begin
          if (cur.op == OP_REGISTER && !reject && held_after == HELD_W'(1)) begin
            state_next = ST_GAP;
          end else begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_GAP: begin
        if (can_emit) state_next = too_soon ? ST_FLUSH : ST_WALK;
      end
      ST_WALK: begin
        if (can_emit && at_end) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop     = 1'b0;
    emit_en     = 1'b0;
    flush_en    = 1'b0;
    emit_status = S_DONE;
    emit_id     = '0;
    emit_held   = held;
    unique case (state)
      ST_IDLE: cmd_pop = cmd_valid;
      ST_FIND: ;
      ST_EDIT: begin
        emit_en = can_emit;
        if (cur.op == OP_REGISTER) begin
          emit_status = reject ? S_TABLE_FULL : S_DONE;
          emit_held   = reject ? held : held_after;
        end else if (cur.op == OP_REMOVE) begin
          emit_status = hit ? S_DONE : S_NOT_FOUND;
          emit_held   = hit ? held - 1'b1 : held;
        end
      end
      ST_GAP: begin
        emit_en     = can_emit && too_soon;
        emit_status = S_SUPPRESSED;
      end
      ST_WALK: begin
        if (at_end) begin
          emit_en     = can_emit && !found;
          emit_status = S_PASS_EMPTY;
        end else begin
          emit_en     = can_emit && pow2;
          emit_status = S_SEARCH;
          emit_id     = id_at;
        end
      end
      ST_FLUSH: flush_en = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cur <= cmd;
          idx <= '0;
          if (cmd.op == OP_BOOST) begin
            for (int j = 0; j < TABLE_SLOTS; j++) cnts[j] <= 16'd1;
          end
        end
      end
      ST_FIND: begin
        if (scan_more) idx <= idx + 1'b1;
      end
      ST_EDIT: begin
        if (can_emit && cur.op == OP_REGISTER) begin
          if (hit) begin
            cnts[sidx] <= start;
          end else if (!full) begin
            for (int j = 1; j < TABLE_SLOTS; j++) begin
              if (HELD_W'(j) > idx) begin
                ids[j]  <= ids[j-1];
                cnts[j] <= cnts[j-1];
              end
            end
            ids[sidx]  <= cur.channel_id;
            cnts[sidx] <= start;
          end
        end else if (can_emit && cur.op == OP_REMOVE && hit) begin
          for (int j = 0; j < TABLE_SLOTS - 1; j++) begin
            if (HELD_W'(j) >= idx) begin
              ids[j]  <= ids[j+1];
              cnts[j] <= cnts[j+1];
            end
          end
        end
      end
      ST_GAP: begin
        if (can_emit && !too_soon) begin
          idx   <= '0;
          found <= 1'b0;
        end
      end
      ST_WALK: begin
        if (can_emit && !at_end) begin
          cnts[sidx] <= cnt_step;
          idx        <= idx + 1'b1;
          if (pow2) found <= 1'b1;
        end
      end
      default: ;
    endcase

    if (emit_en) begin
      if (pend_valid) begin
        rsp <= pend;
      end
      pend <= {emit_status, emit_id, 1'b0, 7'(emit_held)};
    end
    if (flush_en) begin
      rsp <= {pend.status, pend.search_id, 1'b1, pend.entries_held};
    end

    if (rst) begin
      state      <= ST_IDLE;
      held       <= '0;
      last_pass  <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EDIT && can_emit) begin
        if (cur.op == OP_REGISTER && !reject) held <= held_after;
        if (cur.op == OP_REMOVE && hit) held <= held - 1'b1;
      end
      if (state == ST_GAP && can_emit && !too_soon) last_pass <= cur.now_ms;
      if ((emit_en && pend_valid) || flush_en) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (emit_en) begin
        pend_valid <= 1'b1;
      end
      if (flush_en) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/search_retry_backoff_table_unit.sv
// Register, unregister and response run an ordered scan to the slot, one a cycle, then one
// edit. Ticks, new-server requests and a register that leaves one entry held run a pass;
// unless the pass gap suppresses it, it walks every held entry, one a cycle while responses
// are taken. The engine takes one request at a time; a two-deep queue takes requests.
// Reset: synchronous; table empty, last pass time zero, registers at defaults.
// Depends on srbt_pkg, srbt_front and srbt_back.
module search_retry_backoff_table_unit import srbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pass_gap_ms    <= PASS_GAP_RESET;
      cfg.count_ceiling  <= CEILING_RESET;
      cfg.fallback_count <= FALLBACK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PASS_GAP: cfg.pass_gap_ms    <= cfg_data;
        CFG_CEILING:  cfg.count_ceiling  <= cfg_data;
        CFG_FALLBACK: cfg.fallback_count <= cfg_data;
        default: ;
      endcase
    end
  end

  srbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  srbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.entries_held <= 7'(TABLE_SLOTS))
    else $error("entries_held beyond table size");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == S_NOT_FOUND || rsp.status == S_TABLE_FULL ||
                  rsp.status == S_SUPPRESSED || rsp.status == S_PASS_EMPTY) |-> rsp.last)
    else $error("terminal status without last");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != S_SEARCH |-> rsp.search_id == '0)
    else $error("search_id set on non-search response");

endmodule

>>> tb/tb_search_retry_backoff_table_unit.sv
// Self-checking testbench for search_retry_backoff_table_unit: drives requests and
// register writes, predicts every response from a local table model. Depends on srbt_pkg.
`timescale 1ns / 1ps
module tb_search_retry_backoff_table_unit;
  import srbt_pkg::*;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  search_retry_backoff_table_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] gap_ms, ceiling, fallback;
  logic [31:0] tbl_id[TABLE_SLOTS];
  logic [15:0] tbl_count[TABLE_SLOTS];
  int          held;
  logic [31:0] last_pass;

  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  int          errors;
  int          idle_cycles;
  int          sender_hold, receiver_hold;
  bit          quiet_phase;
  bit          cfg_pending;
  logic [1:0]  cfg_pend_index;
  logic [15:0] cfg_pend_data;

  function automatic void queue_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void push_rsp(status_t s, logic [31:0] id);
    rsp_t r;
    r.status = s;
    r.search_id = id;
    r.last = 1'b0;
    r.entries_held = 7'(held);
    expected_rsps = {expected_rsps, r};
  endfunction

  function automatic void run_pass(logic [31:0] now);
    bit found;
    logic [15:0] c;
    found = 0;
    if (32'(now - last_pass) < {16'd0, gap_ms}) begin
      push_rsp(S_SUPPRESSED, 32'd0);
      return;
    end
    last_pass = now;
    for (int i = 0; i < held; i++) begin
      c = tbl_count[i];
      tbl_count[i] = (c >= ceiling) ? fallback : 16'(c + 16'd1);
      if (c != 0 && (c & (c - 16'd1)) == 0) begin
        push_rsp(S_SEARCH, tbl_id[i]);
        found = 1;
      end
    end
    if (!found) push_rsp(S_PASS_EMPTY, 32'd0);
  endfunction

  function automatic void predict_request(req_t r);
    int pos;
    int first;
    logic [15:0] start;
    first = expected_rsps.size();
    pos = 0;
    while (pos < held && tbl_id[pos] < r.channel_id) pos++;
    case (r.mode)
      MODE_REGISTER: begin
        start = r.penalize ? fallback : 16'd1;
        if (pos < held && tbl_id[pos] == r.channel_id) begin
          tbl_count[pos] = start;
          push_rsp(S_DONE, 32'd0);
          if (held == 1) run_pass(r.now_ms);
        end else if (held >= TABLE_SLOTS) begin
          push_rsp(S_TABLE_FULL, 32'd0);
        end else begin
          for (int i = held; i > pos; i--) begin
            tbl_id[i] = tbl_id[i-1];
            tbl_count[i] = tbl_count[i-1];
          end
          tbl_id[pos] = r.channel_id;
          tbl_count[pos] = start;
          held++;
          push_rsp(S_DONE, 32'd0);
          if (held == 1) run_pass(r.now_ms);
        end
      end
      MODE_UNREGISTER, MODE_RESPONSE: begin
        if (pos < held && tbl_id[pos] == r.channel_id) begin
          for (int i = pos; i < held - 1; i++) begin
            tbl_id[i] = tbl_id[i+1];
            tbl_count[i] = tbl_count[i+1];
          end
          held--;
          push_rsp(S_DONE, 32'd0);
        end else begin
          push_rsp(S_NOT_FOUND, 32'd0);
        end
      end
      MODE_NEW_SERVER: begin
        for (int i = 0; i < held; i++) tbl_count[i] = 16'd1;
        run_pass(r.now_ms);
      end
      MODE_TICK: run_pass(r.now_ms);
      default: push_rsp(S_DONE, 32'd0);
    endcase
    if (expected_rsps.size() > first) expected_rsps[expected_rsps.size()-1].last = 1'b1;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_ready <= 1'b0;
      cfg_valid <= 1'b0;
      sender_hold <= 0;
      receiver_hold <= 0;
    end else begin
      if (req_valid && req_ready) predict_request(req);
      if (!req_valid || req_ready) begin
        if (sender_hold > 0) begin
          sender_hold <= sender_hold - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            sender_hold <= $urandom_range(1, 8);
            req_valid <= 1'b0;
          end else begin
            req <= pending_reqs.pop_front();
            req_valid <= 1'b1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
      if (receiver_hold > 0) begin
        receiver_hold <= receiver_hold - 1;
        rsp_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        receiver_hold <= $urandom_range(1, 8);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PASS_GAP: gap_ms = cfg_data;
          CFG_CEILING:  ceiling = cfg_data;
          CFG_FALLBACK: fallback = cfg_data;
          default: ;
        endcase
        cfg_pending = 0;
        cfg_valid <= 1'b0;
      end else if (cfg_pending && !cfg_valid) begin
        cfg_valid <= 1'b1;
        cfg_index <= cfg_pend_index;
        cfg_data <= cfg_pend_data;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response status=%0d id=%h", rsp.status, rsp.search_id);
        errors++;
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status); errors++;
        end
        if (rsp.search_id !== e.search_id) begin
          $error("search_id exp %h got %h", e.search_id, rsp.search_id); errors++;
        end
        if (rsp.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, rsp.last); errors++;
        end
        if (rsp.entries_held !== e.entries_held) begin
          $error("entries_held exp %0d got %0d", e.entries_held, rsp.entries_held);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic req_t make_req(logic [2:0] m, logic [31:0] id, logic pen,
                                    logic [31:0] now);
    req_t r;
    r.mode = m;
    r.channel_id = id;
    r.penalize = pen;
    r.now_ms = now;
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_pend_index = idx;
    cfg_pend_data = val;
    cfg_pending = 1;
    while (cfg_pending) @(posedge clk);
    @(posedge clk);
  endtask

  logic [31:0] clock_ms;
  logic [31:0] id_pool[16];

  task automatic random_phase(int n);
    logic [2:0] m;
    logic [31:0] id;
    for (int k = 0; k < n; k++) begin
      clock_ms += $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(50, 400);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: m = MODE_REGISTER;
        4: m = MODE_UNREGISTER;
        5: m = MODE_RESPONSE;
        6: m = MODE_NEW_SERVER;
        7, 8: m = MODE_TICK;
        default: m = 3'($urandom_range(5, 7));
      endcase
      id = $urandom_range(0, 3) == 0 ? $urandom() : id_pool[$urandom_range(0, 15)];
      queue_req(make_req(m, id, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 19) == 0 ? $urandom() : clock_ms));
    end
  endtask

  initial begin
    errors = 0;
    held = 0;
    last_pass = 0;
    gap_ms = PASS_GAP_RESET;
    ceiling = CEILING_RESET;
    fallback = FALLBACK_RESET;
    quiet_phase = 0;
    cfg_pending = 0;
    clock_ms = 0;
    req_valid = 0;
    rsp_ready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    req = '0;
    for (int i = 0; i < 16; i++) id_pool[i] = $urandom();
    id_pool[0] = 32'd0;
    id_pool[1] = 32'hFFFF_FFFF;
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every mode, suppression, wrap, full table
    queue_req(make_req(MODE_TICK, 32'd5, 1'b0, 32'd50));
    queue_req(make_req(MODE_UNREGISTER, 32'd7, 1'b0, 32'd0));
    queue_req(make_req(MODE_REGISTER, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF));
    queue_req(make_req(MODE_REGISTER, 32'd0, 1'b1, 32'd200));
    queue_req(make_req(MODE_REGISTER, 32'hFFFF_FFFF, 1'b1, 32'd300));
    queue_req(make_req(MODE_TICK, 32'd0, 1'b0, 32'd400));
    queue_req(make_req(MODE_NEW_SERVER, 32'd0, 1'b0, 32'd401));
    queue_req(make_req(MODE_NEW_SERVER, 32'd0, 1'b0, 32'd600));
    queue_req(make_req(MODE_RESPONSE, 32'd0, 1'b0, 32'd0));
    queue_req(make_req(3'd5, 32'd1, 1'b1, 32'd1));
    queue_req(make_req(3'd7, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF));
    queue_req(make_req(MODE_UNREGISTER, 32'hFFFF_FFFF, 1'b0, 32'd0));
    for (int i = 0; i < 33; i++)
      queue_req(make_req(MODE_REGISTER, $urandom(), 1'b0, 32'd700));
    drain();

    // fast backoff: tiny ceiling, zero gap
    write_reg(CFG_PASS_GAP, 16'd0);
    write_reg(CFG_CEILING, 16'd2);
    write_reg(CFG_FALLBACK, 16'd1);
    for (int i = 0; i < 6; i++)
      queue_req(make_req(MODE_TICK, 32'd0, 1'b0, 32'd0));
    for (int i = 0; i < 32; i++)
      queue_req(make_req(MODE_UNREGISTER, id_pool[i % 16], 1'b0, 32'd0));
    drain();

    write_reg(CFG_PASS_GAP, 16'd100);
    write_reg(CFG_CEILING, 16'd256);
    write_reg(CFG_FALLBACK, 16'd129);
    random_phase(50);
    drain();

    // wide settings: ceiling and fallback at 16'h8000, pass gap at its 16-bit maximum
    write_reg(CFG_PASS_GAP, 16'hFFFF);
    write_reg(CFG_CEILING, 16'h8000);
    write_reg(CFG_FALLBACK, 16'h8000);
    random_phase(30);
    drain();

    write_reg(CFG_PASS_GAP, 16'd20);
    write_reg(CFG_CEILING, 16'd8);
    write_reg(CFG_FALLBACK, 16'd5);
    random_phase(40);
    drain();

    write_reg(CFG_PASS_GAP, 16'd0);
    write_reg(CFG_CEILING, 16'd16);
    write_reg(CFG_FALLBACK, 16'd3);
    random_phase(40);
    while (pending_reqs.size() > 0) @(posedge clk);
    quiet_phase = 1;
    random_phase(20);
    drain();

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
